/* design/rmsdb_pkg.sv */
`timescale 1ns / 1ps

package rmsdb_pkg;

    localparam int SAMPLE_W       = 10;
    localparam int LEVEL_W        = 8;
    localparam int MAG_W          = 10;
    localparam int SQ_W           = 19;
    localparam int CENTER         = 512;
    localparam int FULL_SQUARE    = 262144;
    localparam int DEFAULT_WINDOW = 20;
    localparam int NMAG           = 128;
    localparam int KMAG_W         = $clog2(NMAG + 1);
    localparam int WIDE_W         = 1024;

    function automatic int sum_width(input int window);
        return $clog2(window * FULL_SQUARE + 1);
    endfunction

    // Largest sum s with s^10 * 10^n <= (window * FULL_SQUARE)^10.
    function automatic logic [31:0] thresh(input int window, input int n);
        logic [WIDE_W-1:0] full10;
        logic [WIDE_W-1:0] pow10;
        logic [WIDE_W-1:0] prod;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [31:0]       mid;
        full10 = WIDE_W'(1);
        for (int i = 0; i < 10; i++) begin
            full10 = full10 * WIDE_W'(window * FULL_SQUARE);
        end
        pow10 = WIDE_W'(1);
        for (int i = 0; i < n; i++) begin
            pow10 = pow10 * WIDE_W'(10);
        end
        lo = 32'd0;
        hi = 32'(window * FULL_SQUARE);
        while (lo < hi) begin
            mid  = lo + ((hi - lo + 32'd1) >> 1);
            prod = pow10;
            for (int i = 0; i < 10; i++) begin
                prod = prod * WIDE_W'(mid);
            end
            if (prod <= full10) begin
                lo = mid;
            end else begin
                hi = mid - 32'd1;
            end
        end
        return lo;
    endfunction

endpackage

/* design/rmsdb_level.sv */
`timescale 1ns / 1ps

module rmsdb_level #(
    parameter int WINDOW = rmsdb_pkg::DEFAULT_WINDOW
) (
    input  logic        [rmsdb_pkg::sum_width(WINDOW)-1:0] i_sum,
    output logic signed [rmsdb_pkg::LEVEL_W-1:0]           o_level_db
);
    import rmsdb_pkg::*;

    localparam int SUM_W = sum_width(WINDOW);

    logic [NMAG+1:0]   w_hit;
    logic [KMAG_W-1:0] w_k;

    assign w_hit[0]      = 1'b1;
    assign w_hit[NMAG+1] = 1'b0;

    for (genvar gn = 1; gn <= NMAG; gn++) begin : g_cmp
        localparam logic [31:0] THR = thresh(WINDOW, gn);
        assign w_hit[gn] = (i_sum <= THR[SUM_W-1:0]);
    end

    // thermometer to binary: the top set bit gives the magnitude
    always_comb begin
        w_k = '0;
        for (int n = 1; n <= NMAG; n++) begin
            w_k = w_k | (KMAG_W'(n) & {KMAG_W{w_hit[n] & ~w_hit[n+1]}});
        end
    end

    assign o_level_db = LEVEL_W'(~w_k + KMAG_W'(1));

endmodule

/* design/rms_level_db_meter_unit.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                        payload
// sample    in         i_sample_valid / o_sample_stall  i_sample   (10 b unsigned)
// level     out        o_level_valid  / i_level_stall   o_level_db (8 b signed)
//
// One sample is taken every cycle while o_sample_stall is low; the square and the accumulate are each registered.
// A window-closing sample's level passes through r_sq, r_sum and r_level before it shows.
// The level comes from a bank of threshold compares in the last stage.
// Synchronous reset clears the valids, the accumulator and the sample count.
// A stall on the level side backs up through the three stages to o_sample_stall.
module rms_level_db_meter_unit #(
    parameter int WINDOW = rmsdb_pkg::DEFAULT_WINDOW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_sample_valid,
    output logic                                o_sample_stall,
    input  logic        [rmsdb_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_level_valid,
    input  logic                                i_level_stall,
    output logic signed [rmsdb_pkg::LEVEL_W-1:0]  o_level_db
);
    import rmsdb_pkg::*;

    localparam int SUM_W = sum_width(WINDOW);
    localparam int CNT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic                       r_sq_vld;
    logic [SQ_W-1:0]            r_sq;
    logic [SUM_W-1:0]           r_acc;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_sum_vld;
    logic [SUM_W-1:0]           r_sum;
    logic                       r_out_vld;
    logic signed [LEVEL_W-1:0]  r_level;

    logic [MAG_W-1:0]           w_mag;
    logic [SQ_W-1:0]            n_sq;
    logic [SUM_W-1:0]           n_acc;
    logic                       w_last;
    logic                       w_rdy1;
    logic                       w_rdy2;
    logic                       w_rdy3;
    logic                       w_take;
    logic                       w_mv1;
    logic                       w_mv2;
    logic signed [LEVEL_W-1:0]  n_level;

    assign w_rdy3 = !r_out_vld || !i_level_stall;
    assign w_rdy2 = !r_sum_vld || w_rdy3;
    assign w_rdy1 = !r_sq_vld || w_rdy2;
    assign w_take = i_sample_valid && w_rdy1;
    assign w_mv1  = r_sq_vld && w_rdy2;
    assign w_mv2  = r_sum_vld && w_rdy3;

    assign o_sample_stall = !w_rdy1;
    assign o_level_valid  = r_out_vld;
    assign o_level_db     = r_level;

    assign w_mag = (i_sample >= SAMPLE_W'(CENTER)) ? MAG_W'(i_sample - SAMPLE_W'(CENTER))
                                                  : MAG_W'(SAMPLE_W'(CENTER) - i_sample);
    assign n_sq   = SQ_W'(w_mag) * SQ_W'(w_mag);
    assign n_acc  = r_acc + SUM_W'(r_sq);
    assign w_last = (r_cnt == CNT_W'(WINDOW - 1));

    rmsdb_level #(
        .WINDOW (WINDOW)
    ) u_level (
        .i_sum      (r_sum),
        .o_level_db (n_level)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc     <= '0;
            r_cnt     <= '0;
        end else begin
            if (w_take) begin
                r_sq_vld <= 1'b1;
            end else if (w_mv1) begin
                r_sq_vld <= 1'b0;
            end
            if (w_mv1) begin
                if (w_last) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else begin
                    r_acc <= n_acc;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
            if (w_mv1 && w_last) begin
                r_sum_vld <= 1'b1;
            end else if (w_mv2) begin
                r_sum_vld <= 1'b0;
            end
            if (w_mv2) begin
                r_out_vld <= 1'b1;
            end else if (w_rdy3) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sq <= n_sq;
        end
        if (w_mv1 && w_last) begin
            r_sum <= n_acc;
        end
        if (w_mv2) begin
            r_level <= n_level;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW - 1))
        else $error("sample count past window");

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_acc == '0))
        else $error("accumulator not clear at window start");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_level_valid) |-> $past(r_sum_vld))
        else $error("level without a closed window");

    a_level_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_level_valid |-> (o_level_db[LEVEL_W-1] || (o_level_db == '0)))
        else $error("positive level");
`endif

endmodule

/* verif/tb_rms_level_db_meter_unit.sv */
`timescale 1ns / 1ps

module tb_rms_level_db_meter_unit;

    import rmsdb_pkg::*;

    localparam int WIN          = DEFAULT_WINDOW;
    localparam int FULL_SUM     = DEFAULT_WINDOW * FULL_SQUARE;
    localparam int POW_W        = 768;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 250;
    localparam int AMP_RAILS    = 2000;

    typedef struct {
        logic [SAMPLE_W-1:0]       base;
        logic [SAMPLE_W-1:0]       lead;
        int                        lead_n;
        bit                        typed;
        logic signed [LEVEL_W-1:0] level;
    } t_window_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_sample_valid;
    logic                        o_sample_stall;
    logic [SAMPLE_W-1:0]         i_sample;
    logic                        o_level_valid;
    logic                        i_level_stall;
    logic signed [LEVEL_W-1:0]   o_level_db;

    logic signed [LEVEL_W-1:0]   levels_due[$];
    logic signed [LEVEL_W-1:0]   level_want;
    logic [31:0]                 square_sum;
    int                          window_fill;
    int                          mismatches;
    bit                          quiet;
    bit                          hold_req;
    bit                          row_typed;
    logic signed [LEVEL_W-1:0]   row_level;
    int                          stall_left;

    t_window_row window_rows[4] = '{
        '{10'd512,  10'd512, 0,  1'b1, -8'sd128},
        '{10'd0,    10'd0,   0,  1'b1, 8'sd0},
        '{10'd512,  10'd513, 1,  1'b1, -8'sd67},
        '{10'd1023, 10'd0,   10, 1'b0, 8'sd0}
    };

    int amp_modes[10] = '{0, 1, 3, 10, 40, 150, 400, 511, 1023, AMP_RAILS};

    rms_level_db_meter_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sample       (i_sample),
        .o_level_valid  (o_level_valid),
        .i_level_stall  (i_level_stall),
        .o_level_db     (o_level_db)
    );

    always #5 i_clk = ~i_clk;

    // truncated dB level of a window sum, found by exact power comparison
    function automatic logic signed [LEVEL_W-1:0] db_level_of(input logic [31:0] sum);
        logic [POW_W-1:0] sum_pow;
        logic [POW_W-1:0] full_pow;
        int               mag;
        if (sum == 32'd0) begin
            return -8'sd128;
        end
        sum_pow  = POW_W'(1);
        full_pow = POW_W'(1);
        for (int i = 0; i < 10; i++) begin
            sum_pow  = sum_pow * POW_W'(sum);
            full_pow = full_pow * POW_W'(FULL_SUM);
        end
        mag = 0;
        while (mag < NMAG) begin
            sum_pow = sum_pow * POW_W'(10);
            if (sum_pow > full_pow) begin
                break;
            end
            mag++;
        end
        return LEVEL_W'(-mag);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] noisy_sample(input int amp);
        int v;
        if (amp == AMP_RAILS) begin
            return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
        end
        if (amp > 511) begin
            return SAMPLE_W'($urandom_range(0, 1023));
        end
        v = CENTER + int'($urandom_range(0, 2 * amp)) - amp;
        if (v < 0) begin
            v = 0;
        end
        if (v > 1023) begin
            v = 1023;
        end
        return SAMPLE_W'(v);
    endfunction

    // accumulate one taken sample; close the window on the last one
    function automatic void take_sample(input logic [SAMPLE_W-1:0] s);
        int mag;
        mag = (s >= CENTER) ? (int'(s) - CENTER) : (CENTER - int'(s));
        square_sum  = square_sum + 32'(mag * mag);
        window_fill = window_fill + 1;
        if (window_fill == WIN) begin
            levels_due.push_back(row_typed ? row_level : db_level_of(square_sum));
            square_sum  = 32'd0;
            window_fill = 0;
        end
    endfunction

    task automatic offer_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do begin
            @(posedge i_clk);
        end while (o_sample_stall);
        take_sample(s);
    endtask

    task automatic drain_levels();
        while (levels_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // receiver stall: random gaps, plus one long hold on request
    initial begin
        i_level_stall = 1'b0;
        stall_left    = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_level_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                i_level_stall <= 1'b1;
            end else if (quiet || !i_rst_n) begin
                i_level_stall <= 1'b0;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    i_level_stall <= 1'b1;
                end else begin
                    i_level_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_level_valid && !i_level_stall) begin
            if (levels_due.size() == 0) begin
                $display("%0t: level_db expected none got %0d", $time, o_level_db);
                mismatches++;
            end else begin
                level_want = levels_due.pop_front();
                if (o_level_db !== level_want) begin
                    $display("%0t: level_db expected %0d got %0d",
                             $time, level_want, o_level_db);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int amp;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_sample_valid = 1'b0;
        i_sample       = '0;
        square_sum     = 32'd0;
        window_fill    = 0;
        mismatches     = 0;
        quiet          = 1'b0;
        hold_req       = 1'b0;
        row_typed      = 1'b0;
        row_level      = '0;
        amp            = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (window_rows[r]) begin
            row_typed = window_rows[r].typed;
            row_level = window_rows[r].level;
            for (int i = 0; i < WIN; i++) begin
                offer_sample((i < window_rows[r].lead_n) ? window_rows[r].lead
                                                         : window_rows[r].base);
            end
        end
        row_typed = 1'b0;

        // hold the sender until every level is out
        i_sample_valid <= 1'b0;
        drain_levels();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % WIN == 0) begin
                amp = amp_modes[$urandom_range(0, 9)];
            end
            if (n % 100 == 0) begin
                quiet = ((n / 100) % 3 == 1);
            end
            if (n == 300) begin
                hold_req = 1'b1;
            end
            if (n == 560) begin
                i_sample_valid <= 1'b0;
                drain_levels();
            end
            offer_sample(noisy_sample(amp));
        end
        i_sample_valid <= 1'b0;

        drain_levels();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
